// File: rtl/assert_macros.svh
// Assertion helpers used by ratiometric_resistance_scanner.
// Both macros expect a clock named clk in scope; RRS_ASSERT also expects a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define RRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define RRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared constants and types of the ratiometric resistance scanner.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // Converter width default
  localparam int ADC_BITS_DEF = 20;

  // Register field widths
  localparam int OHMS_W     = 16;
  localparam int THR_W      = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int RES_W      = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_OHMS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_REF_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_WIPER_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [OHMS_W-1:0] REFERENCE_OHMS_RST = 16'd32000;
  localparam logic [THR_W-1:0]  OPEN_REF_THR_RST   = 20'd210000;
  localparam logic [THR_W-1:0]  OPEN_WIPER_THR_RST = 20'd200000;

  localparam logic [RES_W-1:0] FULL_SCALE = 16'hFFFF;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // One result beat
  typedef struct packed {
    logic [1:0]       next_mux_channel;
    logic             powered_sensor;
    logic             result_valid;
    logic             result_sensor;
    logic [RES_W-1:0] resistance;
    logic             open_detected;
  } result_t;

endpackage

// File: rtl/rrs_sample_if.sv
// ----------------------------------------------------------------------------
// rrs_sample_if
// Valid/ready channel carrying one finished ADC conversion per beat.
// ----------------------------------------------------------------------------
interface rrs_sample_if #(
  parameter int ADC_BITS = rrs_pkg::ADC_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// File: rtl/rrs_result_if.sv
// ----------------------------------------------------------------------------
// rrs_result_if
// Valid/ready channel carrying one scanner result per beat.
// ----------------------------------------------------------------------------
interface rrs_result_if;
  import rrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       next_mux_channel;
  logic             powered_sensor;
  logic             result_valid;
  logic             result_sensor;
  logic [RES_W-1:0] resistance;
  logic             open_detected;

  modport source (output valid, output next_mux_channel, output powered_sensor,
                  output result_valid, output result_sensor, output resistance,
                  output open_detected, input ready);
  modport sink   (input valid, input next_mux_channel, input powered_sensor,
                  input result_valid, input result_sensor, input resistance,
                  input open_detected, output ready);
endinterface

// File: rtl/ratiometric_resistance_scanner.sv
// Timing: a wiper beat's result appears on the result port in the cycle after acceptance; a
//   reference beat that hits the open, zero-wiper or opposite-sign case goes through S_DONE,
//   and one that needs the divide goes through S_MUL, S_DIV and S_DONE, held in S_DONE while the output stalls.
// Rate: no new sample is taken until a reference beat's result leaves S_DONE; the bit-serial
//   restoring divider runs one quotient bit per cycle over ADC_BITS+16 bits.
// Reset: synchronous rst clears sequencer and scan state, loads register defaults.
// ----------------------------------------------------------------------------
// ratiometric_resistance_scanner
// Pairs wiper and reference conversions of two sensors and returns the
// resistance (reference * reference_ohms) / wiper, with open-circuit detect.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ratiometric_resistance_scanner #(
  parameter int ADC_BITS = rrs_pkg::ADC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrs_pkg::CFG_DATA_W-1:0] cfg_data,
  rrs_sample_if.sink                     sample,
  rrs_result_if.source                   result
);
  import rrs_pkg::*;

  localparam int CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;
  localparam int NUM_W = ADC_BITS + OHMS_W;
  localparam int CNT_W = $clog2(NUM_W);

  // Configuration registers
  logic [OHMS_W-1:0]       reference_ohms;
  logic signed [THR_W-1:0] open_ref_threshold;
  logic signed [THR_W-1:0] open_wiper_threshold;

  // Scan state
  logic                       scan_phase;
  logic                       cur_sensor;
  logic signed [ADC_BITS-1:0] wiper_sample;

  // Sequencer and divider
  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic [ADC_BITS-1:0] ref_mag;
  logic [ADC_BITS-1:0] den;
  logic [ADC_BITS-1:0] rem;
  logic [NUM_W-1:0]    num;
  result_t             pend;

  // Output register
  logic    out_valid;
  result_t out_data;

  // Combinational signals
  logic                    accept;
  logic                    out_free;
  logic                    out_load;
  logic signed [CMP_W-1:0] ref_x;
  logic signed [CMP_W-1:0] wip_x;
  logic signed [CMP_W-1:0] rthr_x;
  logic signed [CMP_W-1:0] wthr_x;
  logic                    open_hit;
  logic                    wip_zero;
  logic                    sign_diff;
  logic [ADC_BITS-1:0]     ref_u;
  logic [ADC_BITS-1:0]     wip_u;
  logic [ADC_BITS:0]       trial;
  logic                    ge;
  logic [ADC_BITS-1:0]     rem_next;
  logic [NUM_W-1:0]        num_next;
  logic                    q_sat;
  result_t                 wip_beat;
  result_t                 ref_beat;

  assign out_free     = !out_valid || result.ready;
  assign sample.ready = (state == S_IDLE) && out_free;
  assign accept       = sample.valid && sample.ready;
  // A new beat enters the output register on a wiper beat or when a result is done
  assign out_load     = (accept && !scan_phase) || ((state == S_DONE) && out_free);

  // Open test and special cases for a reference beat
  always_comb begin
    ref_x     = CMP_W'(sample.adc_sample);
    wip_x     = CMP_W'(wiper_sample);
    rthr_x    = CMP_W'(open_ref_threshold);
    wthr_x    = CMP_W'(open_wiper_threshold);
    open_hit  = (ref_x > rthr_x) && (wip_x < wthr_x);
    wip_zero  = (wiper_sample == '0);
    sign_diff = sample.adc_sample[ADC_BITS-1] != wiper_sample[ADC_BITS-1];
    ref_u     = ADC_BITS'(sample.adc_sample);
    wip_u     = ADC_BITS'(wiper_sample);
  end

  // Result beats formed at acceptance
  always_comb begin
    wip_beat                  = '0;
    wip_beat.next_mux_channel = {cur_sensor, 1'b1};
    wip_beat.powered_sensor   = cur_sensor;

    ref_beat                  = '0;
    ref_beat.next_mux_channel = {~cur_sensor, 1'b0};
    ref_beat.powered_sensor   = ~cur_sensor;
    ref_beat.result_valid     = 1'b1;
    ref_beat.result_sensor    = cur_sensor;
    if (open_hit) begin
      ref_beat.resistance    = FULL_SCALE;
      ref_beat.open_detected = 1'b1;
    end else if (wip_zero) begin
      ref_beat.resistance = FULL_SCALE;
    end
  end

  // One restoring divide step
  always_comb begin
    trial    = {rem, num[NUM_W-1]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? ADC_BITS'(trial - {1'b0, den}) : ADC_BITS'(trial);
    num_next = {num[NUM_W-2:0], ge};
    q_sat    = |num_next[NUM_W-1:RES_W];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_ohms       <= REFERENCE_OHMS_RST;
      open_ref_threshold   <= OPEN_REF_THR_RST;
      open_wiper_threshold <= OPEN_WIPER_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REFERENCE_OHMS:       reference_ohms       <= OHMS_W'(cfg_data);
        REG_OPEN_REF_THRESHOLD:   open_ref_threshold   <= THR_W'(cfg_data);
        REG_OPEN_WIPER_THRESHOLD: open_wiper_threshold <= THR_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Sequencer, scan state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      scan_phase   <= 1'b0;
      cur_sensor   <= 1'b0;
      wiper_sample <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!scan_phase) begin
              wiper_sample <= sample.adc_sample;
              scan_phase   <= 1'b1;
              out_data     <= wip_beat;
            end else begin
              scan_phase <= 1'b0;
              cur_sensor <= ~cur_sensor;
              pend       <= ref_beat;
              ref_mag    <= sample.adc_sample[ADC_BITS-1] ? ADC_BITS'(~ref_u + 1'b1) : ref_u;
              den        <= wiper_sample[ADC_BITS-1] ? ADC_BITS'(~wip_u + 1'b1) : wip_u;
              if (open_hit || wip_zero || sign_diff) begin
                state <= S_DONE;
              end else begin
                state <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          num   <= NUM_W'(ref_mag) * NUM_W'(reference_ohms);
          rem   <= '0;
          cnt   <= CNT_W'(NUM_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_next;
          num <= num_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            pend.resistance <= q_sat ? FULL_SCALE : num_next[RES_W-1:0];
            state           <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data <= pend;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result port
  assign result.valid            = out_valid;
  assign result.next_mux_channel = out_data.next_mux_channel;
  assign result.powered_sensor   = out_data.powered_sensor;
  assign result.result_valid     = out_data.result_valid;
  assign result.result_sensor    = out_data.result_sensor;
  assign result.resistance       = out_data.resistance;
  assign result.open_detected    = out_data.open_detected;

  // Checks
  `RRS_ASSERT(a_busy_blocks_input, (state != S_IDLE) |-> !sample.ready, "input taken while busy")
  `RRS_ASSERT(a_phase_flips, (sample.valid && sample.ready) |=> (scan_phase != $past(scan_phase)), "scan phase did not advance")
  `RRS_ASSERT(a_open_full_scale, (result.valid && result.open_detected) |-> (result.result_valid && result.resistance == FULL_SCALE), "open result not full scale")
  `RRS_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !out_valid), "reset left sequencer busy")

endmodule
